// ----- hw/rtl/eamc_pkg.sv -----
package eamc_pkg;

  // Default build widths
  localparam int POS_BITS_DEF   = 32;
  localparam int BRAKE_BITS_DEF = 24;

  // Fixed field widths
  localparam int TARGET_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [7:0]  BRAKE_DUTY     = 8'd255;
  localparam logic [15:0] HALL_QUIET_MAX = 16'hFFFF;

  // Configuration reset values
  localparam logic        RST_SENSOR_MODE = 1'b0;
  localparam logic [7:0]  RST_FAST_DUTY   = 8'd255;
  localparam logic [7:0]  RST_SLOW_DUTY   = 8'd120;
  localparam logic [23:0] RST_SLOW_ZONE   = 24'd76642;
  localparam logic [15:0] RST_DONE_COUNTS = 16'd1277;
  localparam logic [23:0] RST_BRAKE_TICKS = 24'd250000;
  localparam logic [23:0] RST_STOP_TICKS  = 24'd150000;
  localparam logic [15:0] RST_HALL_DEB    = 16'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_MODE = 3'd0,
    CFG_FAST_DUTY   = 3'd1,
    CFG_SLOW_DUTY   = 3'd2,
    CFG_SLOW_ZONE   = 3'd3,
    CFG_DONE_COUNTS = 3'd4,
    CFG_BRAKE_TICKS = 3'd5,
    CFG_STOP_TICKS  = 3'd6,
    CFG_HALL_DEB    = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_HOME  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BR_COAST = 2'd0,
    BR_FWD   = 2'd1,
    BR_REV   = 2'd2,
    BR_BRAKE = 2'd3
  } bridge_t;

endpackage

// ----- hw/rtl/encoder_axis_move_controller_core.sv -----
// One motor axis: encoder counter plus point-to-point move controller.
//
// Input stream (in_*): one transaction per item. in_tuser carries the command
// (tick with encoder sample, start move, stop, home); in_tdata carries the
// signed target distance and the encoder line levels.
// Output stream (out_*): exactly one result transaction per input item, in
// order: bridge mode, duty, position, moving flag and move-done flag.
// Configuration (cfg_*): plain register writes; the user must make them only
// while idle, as the block itself does not enforce it.
//
// A transaction passes through the input register, then the result register.
// Throughput is one item per clock while out_tready stays high, set by the
// single update pass over the axis state between the two registers.
//
// Reset (rst_n low, synchronous) clears position, move and brake state, sets
// the hall quiet counter to saturated and loads the register defaults.
// A stalled receiver holds the result register; the input register then
// holds one more item, after which in_tready drops until out_tready returns.
module encoder_axis_move_controller_core
  import eamc_pkg::*;
#(
  parameter int POS_BITS   = POS_BITS_DEF,
  parameter int BRAKE_BITS = BRAKE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] target_counts, [32] enc_a, [33] enc_b, [39:34] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] bridge_mode, [9:2] duty, [41:10] position, [42] moving,
  // [43] move_done, [47:44] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  localparam int P  = POS_BITS;
  localparam int PW = (P > TARGET_W) ? P : TARGET_W;     // position output span
  localparam int TW = PW + 1;                            // target clamp width
  localparam int RW = (P + 1 > 25) ? P + 1 : 25;         // remaining distance
  localparam int BW = (BRAKE_BITS > 24) ? BRAKE_BITS : 24;

  localparam logic signed [TW-1:0] TGT_LIM = TW'((64'sd1 <<< (P - 1)) - 64'sd1);
  localparam logic [BW-1:0] BRAKE_MAX = BW'((64'd1 << BRAKE_BITS) - 64'd1);

  // Configuration registers
  logic        sensor_mode_r;
  logic [7:0]  fast_duty_r, slow_duty_r;
  logic [23:0] slow_zone_r, brake_ticks_r, stop_ticks_r;
  logic [15:0] done_counts_r, hall_deb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_mode_r <= RST_SENSOR_MODE;
      fast_duty_r   <= RST_FAST_DUTY;
      slow_duty_r   <= RST_SLOW_DUTY;
      slow_zone_r   <= RST_SLOW_ZONE;
      done_counts_r <= RST_DONE_COUNTS;
      brake_ticks_r <= RST_BRAKE_TICKS;
      stop_ticks_r  <= RST_STOP_TICKS;
      hall_deb_r    <= RST_HALL_DEB;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SENSOR_MODE: sensor_mode_r <= cfg_wdata[0];
        CFG_FAST_DUTY:   fast_duty_r   <= cfg_wdata[7:0];
        CFG_SLOW_DUTY:   slow_duty_r   <= cfg_wdata[7:0];
        CFG_SLOW_ZONE:   slow_zone_r   <= cfg_wdata;
        CFG_DONE_COUNTS: done_counts_r <= cfg_wdata[15:0];
        CFG_BRAKE_TICKS: brake_ticks_r <= cfg_wdata;
        CFG_STOP_TICKS:  stop_ticks_r  <= cfg_wdata;
        CFG_HALL_DEB:    hall_deb_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Input register and pipeline handshake
  logic                       s1_valid_r;
  cmd_t                       s1_cmd_r;
  logic signed [TARGET_W-1:0] s1_target_r;
  logic                       s1_a_r, s1_b_r;
  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r, out_data_nxt;
  logic                       advance;

  // Move the input register forward whenever the result slot is free or drains.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r    <= cmd_t'(in_tuser);
      s1_target_r <= in_tdata[TARGET_W-1:0];
      s1_a_r      <= in_tdata[TARGET_W];
      s1_b_r      <= in_tdata[TARGET_W+1];
    end
  end

  // Axis state
  logic [P-1:0]          pos_r, pos_nxt, start_r, start_nxt;
  logic signed [P-1:0]   target_r, target_nxt;
  logic                  active_r, active_nxt, reverse_r, reverse_nxt;
  logic                  slow_r, slow_nxt;
  logic [BRAKE_BITS-1:0] brake_r, brake_nxt;
  logic                  prev_a_r, prev_a_nxt, prev_hall_r, prev_hall_nxt;
  logic [15:0]           quiet_r, quiet_nxt;
  logic                  done_nxt;

  // Encoder sample for a tick item
  logic [P-1:0] pos_tick;
  logic [15:0]  quiet_tick;

  always_comb begin
    pos_tick   = pos_r;
    quiet_tick = (quiet_r != HALL_QUIET_MAX) ? quiet_r + 16'd1 : quiet_r;
    if (!sensor_mode_r) begin
      if (s1_a_r != prev_a_r) begin
        pos_tick = (s1_b_r != s1_a_r) ? pos_r + P'(1) : pos_r - P'(1);
      end
    end else if (s1_a_r && !prev_hall_r && quiet_tick >= hall_deb_r) begin
      pos_tick   = pos_r + P'(1);
      quiet_tick = 16'd0;
    end
  end

  // Distance check on the freshly sampled count
  logic signed [P-1:0]  moved;
  logic signed [RW-1:0] diff;
  logic [RW-1:0]        remain;
  logic                 reached;

  assign moved   = pos_tick - start_r;
  assign diff    = RW'(target_r) - RW'(moved);
  assign remain  = diff[RW-1] ? RW'(-diff) : RW'(diff);
  assign reached = (sensor_mode_r || !target_r[P-1]) ? (moved >= target_r)
                                                     : (moved <= target_r);

  // Start target: clamp the magnitude into the position range
  logic signed [TW-1:0] tgt_w, tgt_c;
  logic signed [P-1:0]  tgt_p;

  assign tgt_w = TW'(s1_target_r);
  assign tgt_c = (tgt_w > TGT_LIM) ? TGT_LIM : ((tgt_w < -TGT_LIM) ? -TGT_LIM : tgt_w);
  assign tgt_p = tgt_c[P-1:0];

  // Brake lengths saturated to the counter width
  logic [BW-1:0] brake_len_w, stop_len_w;

  assign brake_len_w = (BW'(brake_ticks_r) > BRAKE_MAX) ? BRAKE_MAX : BW'(brake_ticks_r);
  assign stop_len_w  = (BW'(stop_ticks_r) > BRAKE_MAX) ? BRAKE_MAX : BW'(stop_ticks_r);

  always_comb begin
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    target_nxt    = target_r;
    active_nxt    = active_r;
    reverse_nxt   = reverse_r;
    slow_nxt      = slow_r;
    brake_nxt     = brake_r;
    prev_a_nxt    = prev_a_r;
    prev_hall_nxt = prev_hall_r;
    quiet_nxt     = quiet_r;
    done_nxt      = 1'b0;
    case (s1_cmd_r)
      CMD_TICK: begin
        pos_nxt       = pos_tick;
        quiet_nxt     = quiet_tick;
        prev_a_nxt    = s1_a_r;
        prev_hall_nxt = s1_a_r;
        if (brake_r != '0) begin
          brake_nxt = brake_r - BRAKE_BITS'(1);
        end
        if (active_r) begin
          if (remain < RW'(slow_zone_r)) begin
            slow_nxt = 1'b1;
          end
          // Target reached or inside the done band: brake, then coast.
          if (reached || remain <= RW'(done_counts_r)) begin
            active_nxt = 1'b0;
            slow_nxt   = 1'b0;
            brake_nxt  = brake_len_w[BRAKE_BITS-1:0];
            done_nxt   = 1'b1;
          end
        end
      end
      CMD_START: begin
        // Ignore a zero distance; otherwise restart from the current count.
        if (s1_target_r != '0) begin
          reverse_nxt = tgt_p[P-1];
          target_nxt  = (sensor_mode_r && tgt_p[P-1]) ? -tgt_p : tgt_p;
          start_nxt   = pos_r;
          active_nxt  = 1'b1;
          slow_nxt    = 1'b0;
          brake_nxt   = '0;
        end
      end
      CMD_STOP: begin
        active_nxt = 1'b0;
        slow_nxt   = 1'b0;
        brake_nxt  = stop_len_w[BRAKE_BITS-1:0];
      end
      CMD_HOME: begin
        pos_nxt = '0;
      end
      default: ;
    endcase
  end

  // Result fields from the updated state
  bridge_t       bridge_nxt;
  logic [7:0]    duty_nxt;
  logic [PW-1:0] pos_w;

  assign pos_w = PW'(pos_nxt);

  always_comb begin
    if (brake_nxt != '0) begin
      bridge_nxt = BR_BRAKE;
      duty_nxt   = BRAKE_DUTY;
    end else if (active_nxt) begin
      bridge_nxt = reverse_nxt ? BR_REV : BR_FWD;
      duty_nxt   = slow_nxt ? slow_duty_r : fast_duty_r;
    end else begin
      bridge_nxt = BR_COAST;
      duty_nxt   = 8'd0;
    end
    out_data_nxt = {4'b0000, done_nxt, active_nxt, pos_w[TARGET_W-1:0], duty_nxt,
                    bridge_nxt};
  end

  // Commit the state only when an item actually passes to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      start_r     <= '0;
      target_r    <= '0;
      active_r    <= 1'b0;
      reverse_r   <= 1'b0;
      slow_r      <= 1'b0;
      brake_r     <= '0;
      prev_a_r    <= 1'b0;
      prev_hall_r <= 1'b0;
      quiet_r     <= HALL_QUIET_MAX;
    end else if (s1_valid_r && advance) begin
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      target_r    <= target_nxt;
      active_r    <= active_nxt;
      reverse_r   <= reverse_nxt;
      slow_r      <= slow_nxt;
      brake_r     <= brake_nxt;
      prev_a_r    <= prev_a_nxt;
      prev_hall_r <= prev_hall_nxt;
      quiet_r     <= quiet_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Braking and moving exclude each other.
  assert property (@(posedge clk) disable iff (!rst_n)
    (brake_r != '0) |-> !active_r)
    else $error("brake counter running during an active move");

  assert property (@(posedge clk) disable iff (!rst_n)
    slow_r |-> active_r)
    else $error("slow duty latched with no move active");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[TARGET_W+11]) |-> !out_data_r[TARGET_W+10])
    else $error("move_done shown while still moving");

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

endmodule

// ----- tb/encoder_axis_move_controller_core_test.sv -----
`timescale 1ns / 100ps

module encoder_axis_move_controller_core_test;
  import eamc_pkg::*;

  // Stop driving idle gaps and stalls once this many transactions are in.
  localparam int TAIL_START = 1300;
  // Total input transactions, directed part included.
  localparam int ITEM_TOTAL = 1530;
  // Items per random settings phase.
  localparam int PHASE_ITEMS = 120;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  // One result transaction as the block should show it.
  typedef struct {
    bridge_t     mode;
    logic [7:0]  duty;
    logic [31:0] position;
    bit          moving;
    bit          done;
  } axis_status_t;

  // Tracks the axis state, predicts one status per command and checks the
  // results in order against what it predicted.
  class move_tracker;
    // Register copies
    bit          cfg_hall;
    logic [7:0]  fast, slow;
    logic [23:0] slow_zone;
    logic [15:0] done_band;
    logic [23:0] brake_len, stop_len;
    logic [15:0] debounce;
    // Axis state
    logic [31:0] pos, start_pos;
    longint      target;
    bit          active, rev, slow_on;
    logic [23:0] brake_left;
    bit          prev_a, prev_hall;
    logic [15:0] quiet;
    axis_status_t status_q[$];
    int          errors;

    function new();
      cfg_hall = RST_SENSOR_MODE;
      fast = RST_FAST_DUTY;
      slow = RST_SLOW_DUTY;
      slow_zone = RST_SLOW_ZONE;
      done_band = RST_DONE_COUNTS;
      brake_len = RST_BRAKE_TICKS;
      stop_len = RST_STOP_TICKS;
      debounce = RST_HALL_DEB;
      pos = '0;
      start_pos = '0;
      target = 0;
      active = 0;
      rev = 0;
      slow_on = 0;
      brake_left = '0;
      prev_a = 0;
      prev_hall = 0;
      quiet = HALL_QUIET_MAX;
      errors = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [23:0] v);
      case (idx)
        CFG_SENSOR_MODE: cfg_hall = v[0];
        CFG_FAST_DUTY:   fast = v[7:0];
        CFG_SLOW_DUTY:   slow = v[7:0];
        CFG_SLOW_ZONE:   slow_zone = v;
        CFG_DONE_COUNTS: done_band = v[15:0];
        CFG_BRAKE_TICKS: brake_len = v;
        CFG_STOP_TICKS:  stop_len = v;
        CFG_HALL_DEB:    debounce = v[15:0];
        default: ;
      endcase
    endfunction

    function void take_command(cmd_t cmd, logic [31:0] tgt, bit a, bit b);
      logic signed [31:0] moved32;
      longint moved, diff, remain, t;
      longint lim;
      bit reached, done_now;
      axis_status_t r;
      lim = 64'sd2147483647;
      done_now = 0;
      case (cmd)
        CMD_TICK: begin
          if (quiet != HALL_QUIET_MAX) quiet++;
          if (!cfg_hall) begin
            if (a != prev_a) pos = (b != a) ? pos + 32'd1 : pos - 32'd1;
          end else if (a && !prev_hall && quiet >= debounce) begin
            pos = pos + 32'd1;
            quiet = '0;
          end
          prev_a = a;
          prev_hall = a;
          if (brake_left != '0) brake_left--;
          if (active) begin
            moved32 = pos - start_pos;
            moved = moved32;
            diff = target - moved;
            remain = (diff < 0) ? -diff : diff;
            if (cfg_hall || target >= 0) reached = (moved >= target);
            else reached = (moved <= target);
            if (remain < longint'(slow_zone)) slow_on = 1;
            if (reached || remain <= longint'(done_band)) begin
              active = 0;
              slow_on = 0;
              brake_left = brake_len;
              done_now = 1;
            end
          end
        end
        CMD_START: begin
          t = longint'($signed(tgt));
          if (t != 0) begin
            if (t > lim) t = lim;
            if (t < -lim) t = -lim;
            rev = (t < 0);
            target = (cfg_hall && t < 0) ? -t : t;
            start_pos = pos;
            active = 1;
            slow_on = 0;
            brake_left = '0;
          end
        end
        CMD_STOP: begin
          active = 0;
          slow_on = 0;
          brake_left = stop_len;
        end
        default: pos = '0;
      endcase

      if (brake_left != '0) begin
        r.mode = BR_BRAKE;
        r.duty = BRAKE_DUTY;
      end else if (active) begin
        r.mode = rev ? BR_REV : BR_FWD;
        r.duty = slow_on ? slow : fast;
      end else begin
        r.mode = BR_COAST;
        r.duty = '0;
      end
      r.position = pos;
      r.moving = active;
      r.done = done_now;
      status_q.push_back(r);
    endfunction

    function void check_status(logic [OUT_DATA_W-1:0] d);
      axis_status_t e;
      if (status_q.size() == 0) begin
        $error("result transaction with nothing expected: %h", d);
        errors++;
        return;
      end
      e = status_q.pop_front();
      if (d[1:0] !== e.mode) begin
        $error("bridge_mode: expected %0d, actual %0d", e.mode, d[1:0]);
        errors++;
      end
      if (d[9:2] !== e.duty) begin
        $error("duty: expected %0d, actual %0d", e.duty, d[9:2]);
        errors++;
      end
      if (d[41:10] !== e.position) begin
        $error("position: expected %0d, actual %0d", $signed(e.position),
               $signed(d[41:10]));
        errors++;
      end
      if (d[42] !== e.moving) begin
        $error("moving: expected %0d, actual %0d", e.moving, d[42]);
        errors++;
      end
      if (d[43] !== e.done) begin
        $error("move_done: expected %0d, actual %0d", e.done, d[43]);
        errors++;
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [31:0] target_counts, [32] enc_a, [33] enc_b, [39:34] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [1:0] command
  logic [1:0]            in_tuser = CMD_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [1:0] bridge_mode, [9:2] duty, [41:10] position, [42] moving,
  // [43] move_done, [47:44] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SENSOR_MODE;
  logic [CFG_DAT_W-1:0]  cfg_wdata = '0;

  move_tracker sb;
  int          sent = 0;       // accepted input transactions so far
  bit          line_a = 1'b0;  // encoder A level of the last tick sent
  int          idle_cycles = 0;
  logic [23:0] cfg_plan [8];   // register values for the next phase

  encoder_axis_move_controller_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: stall in random bursts, then take and check each transaction.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (sent < TAIL_START && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_status(out_tdata);
    end
  end

  // Present one command, hold it until accepted, then record it for prediction.
  // Leave in_tvalid high on return so back-to-back commands need no extra edge.
  task automatic send_item(cmd_t cmd, logic [31:0] tgt, bit a, bit b);
    if (sent < TAIL_START && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, b, a, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_command(cmd, tgt, a, b);
    if (cmd == CMD_TICK) line_a = a;
    sent++;
  endtask

  // Drain the block, then write all eight registers from cfg_plan.
  task automatic program_registers();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Let the two register stages settle before touching the settings.
    repeat (3) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= cfg_plan[i];
      @(posedge clk);
      sb.set_register(cfg_idx_t'(i), cfg_plan[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // sel 0 picks the bottom of the range, sel 1 the top, anything else random
  // with the extremes weighted in.
  function automatic logic [23:0] extreme_or(logic [23:0] top, int lo, int hi, int sel);
    int r;
    if (sel == 0) return '0;
    if (sel == 1) return top;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return top;
    return 24'($urandom_range(hi, lo));
  endfunction

  task automatic pick_settings(int sel);
    cfg_plan[CFG_SENSOR_MODE] = (sel == 0) ? 24'd0 : (sel == 1) ? 24'd1
                                                   : 24'($urandom_range(0, 1));
    cfg_plan[CFG_FAST_DUTY]   = extreme_or(24'hFF, 1, 254, sel);
    cfg_plan[CFG_SLOW_DUTY]   = extreme_or(24'hFF, 1, 254, sel);
    cfg_plan[CFG_SLOW_ZONE]   = extreme_or(24'hFFFFFF, 1, 30, sel);
    cfg_plan[CFG_DONE_COUNTS] = extreme_or(24'hFFFF, 1, 6, sel);
    cfg_plan[CFG_BRAKE_TICKS] = extreme_or(24'hFFFFFF, 1, 8, sel);
    cfg_plan[CFG_STOP_TICKS]  = extreme_or(24'hFFFFFF, 1, 8, sel);
    cfg_plan[CFG_HALL_DEB]    = extreme_or(24'hFFFF, 1, 4, sel);
  endtask

  // One move: a start with a random target, then mostly encoder steps in
  // the move's direction, mixed with noise, stops, homes and restarts.
  task automatic run_move();
    int r, mag, n;
    logic [31:0] tgt;
    bit fwd, na;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      tgt = '0;
    end else if (r == 1) begin
      tgt = $urandom();
    end else begin
      mag = $urandom_range(1, 24);
      tgt = $urandom_range(0, 1) ? mag : -mag;
    end
    fwd = !tgt[31];
    send_item(CMD_START, tgt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    n = $urandom_range(20, 80);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        // Quadrature step: toggle A, B picks the direction. Hall: B is noise.
        na = ~line_a;
        send_item(CMD_TICK, $urandom(), na,
                  cfg_plan[CFG_SENSOR_MODE][0] ? 1'($urandom_range(0, 1))
                                               : (fwd ? line_a : na));
      end else if (r < 95) begin
        send_item(CMD_TICK, $urandom(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (r < 97) begin
        send_item(CMD_STOP, $urandom(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (r < 98) begin
        send_item(CMD_HOME, $urandom(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        mag = $urandom_range(1, 24);
        tgt = fwd ? mag : -mag;
        send_item(CMD_START, tgt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int phase, phase_start;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a short move ends at once inside the wide done band.
    send_item(CMD_TICK, 32'd0, 1'b0, 1'b0);
    send_item(CMD_START, 32'd5, 1'b0, 1'b0);
    send_item(CMD_TICK, 32'hFFFFFFFF, 1'b1, 1'b0);

    // Directed quadrature run with short brakes and a tiny slow zone.
    cfg_plan[CFG_SENSOR_MODE] = 0;
    cfg_plan[CFG_FAST_DUTY]   = 200;
    cfg_plan[CFG_SLOW_DUTY]   = 40;
    cfg_plan[CFG_SLOW_ZONE]   = 3;
    cfg_plan[CFG_DONE_COUNTS] = 0;
    cfg_plan[CFG_BRAKE_TICKS] = 2;
    cfg_plan[CFG_STOP_TICKS]  = 1;
    cfg_plan[CFG_HALL_DEB]    = 0;
    program_registers();
    send_item(CMD_HOME, 32'd0, 1'b0, 1'b0);
    send_item(CMD_START, 32'd0, 1'b0, 1'b0);    // zero target: ignored
    send_item(CMD_STOP, 32'd0, 1'b0, 1'b0);     // stop while idle still brakes
    send_item(CMD_TICK, 32'd0, 1'b0, 1'b1);     // brake runs out, A unchanged
    send_item(CMD_START, 32'd5, 1'b0, 1'b0);
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b0);
    send_item(CMD_TICK, 32'd0, 1'b0, 1'b1);
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b0);     // inside slow zone
    send_item(CMD_START, 32'd5, 1'b0, 1'b0);    // restart while moving
    send_item(CMD_TICK, 32'd0, 1'b0, 1'b1);
    send_item(CMD_HOME, 32'd0, 1'b0, 1'b0);     // home mid-move keeps start
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b0);
    send_item(CMD_STOP, 32'd0, 1'b0, 1'b0);     // stop mid-move
    send_item(CMD_START, 32'h80000000, 1'b0, 1'b0);  // saturated reverse target
    send_item(CMD_TICK, 32'd0, 1'b0, 1'b0);
    send_item(CMD_START, 32'h7FFFFFFF, 1'b1, 1'b1);  // widest forward target
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b0);
    send_item(CMD_START, 32'hFFFFFFFE, 1'b0, 1'b0);  // reverse by two
    send_item(CMD_TICK, 32'd0, 1'b0, 1'b0);
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);     // reaches target, brakes
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);     // brake over, coast

    // Directed hall run: debounce of three ticks, no brake after a move.
    cfg_plan[CFG_SENSOR_MODE] = 1;
    cfg_plan[CFG_FAST_DUTY]   = 255;
    cfg_plan[CFG_SLOW_DUTY]   = 0;
    cfg_plan[CFG_SLOW_ZONE]   = 0;
    cfg_plan[CFG_BRAKE_TICKS] = 0;
    cfg_plan[CFG_STOP_TICKS]  = 0;
    cfg_plan[CFG_HALL_DEB]    = 3;
    program_registers();
    send_item(CMD_TICK, 32'd0, 1'b0, 1'b0);
    send_item(CMD_START, 32'hFFFFFFFE, 1'b0, 1'b0);  // hall takes the magnitude
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b0);     // first edge always counts
    send_item(CMD_TICK, 32'd0, 1'b0, 1'b1);
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b1);     // too soon: dropped
    send_item(CMD_TICK, 32'd0, 1'b0, 1'b0);
    send_item(CMD_TICK, 32'd0, 1'b1, 1'b0);     // counts, done, coasts at once
    send_item(CMD_STOP, 32'd0, 1'b0, 1'b0);     // zero stop brake

    // Random phases: first all settings at the bottom, then at the top,
    // then mixed.
    phase = 0;
    while (sent < ITEM_TOTAL) begin
      pick_settings(phase);
      program_registers();
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS && sent < ITEM_TOTAL) run_move();
      phase++;
    end

    // Drain and let the pipeline go quiet before the verdict.
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
